FILE: sv/encoder_gyro_dead_reckoning_core_defines.svh
// Assertion macros for the dead-reckoning core
`ifndef ENCODER_GYRO_DEAD_RECKONING_CORE_DEFINES_SVH
`define ENCODER_GYRO_DEAD_RECKONING_CORE_DEFINES_SVH

`ifndef SYNTH
`define EGDR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define EGDR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define EGDR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define EGDR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/egdr_pkg.sv
package egdr_pkg;

    // one full turn in 1/64 degree
    localparam logic [15:0] TURN_UNITS = 16'd23040;
    localparam int MM_W = 24;
    localparam int MAG_W = 17;
    localparam int STEP_W = 41;
    localparam int POS_W = 48;
    localparam int INC_W = 42;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIST,
        ST_ROM_S,
        ST_ROM_C,
        ST_ROM_W,
        ST_MUL_X,
        ST_MUL_Y,
        ST_DONE
    } state_t;

    // add an increment to a 48-bit accumulator, clamp at the signed limits
    function automatic logic signed [POS_W-1:0] sat_add48(
        input logic signed [POS_W-1:0] a,
        input logic signed [INC_W-1:0] b
    );
        logic signed [POS_W:0] s;
        s = {a[POS_W-1], a} + {{(POS_W-INC_W+1){b[INC_W-1]}}, b};
        if (s[POS_W] != s[POS_W-1]) begin
            sat_add48 = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_add48 = s[POS_W-1:0];
        end
    endfunction

endpackage

FILE: sv/egdr_serial_mul.sv
module egdr_serial_mul import egdr_pkg::*; #(
    parameter int AW = 41,
    parameter int BW = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [AW-1:0]  op_a,
    input  logic [BW-1:0]         op_b,
    output logic                  busy,
    output logic signed [AW+BW-1:0] product
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] acc_reg;
    logic [PW-1:0] mcand_reg;
    logic [BW-1:0] mplier_reg;
    logic [CW-1:0] cnt_reg;

    // count down one multiplier bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start && cnt_reg == '0) begin
            cnt_reg <= CW'(BW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // shift and add: multiplicand left, multiplier right
    always_ff @(posedge aclk) begin
        if (start && cnt_reg == '0) begin
            acc_reg    <= '0;
            mcand_reg  <= {{BW{op_a[AW-1]}}, op_a};
            mplier_reg <= op_b;
        end else if (cnt_reg != '0) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[BW-1:1]};
        end
    end

    assign busy    = (cnt_reg != '0);
    assign product = acc_reg;

endmodule

FILE: sv/egdr_serial_div.sv
module egdr_serial_div import egdr_pkg::*; #(
    parameter int NW = 27
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] numer,
    output logic          busy,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [14:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [15:0]   trial;
    logic          qbit;

    // restoring step against one turn
    always_comb begin
        trial = {rem_reg, num_reg[NW-1]};
        qbit  = (trial >= TURN_UNITS);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start && cnt_reg == '0) begin
            cnt_reg <= CW'(NW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // shift numerator out, quotient bits in
    always_ff @(posedge aclk) begin
        if (start && cnt_reg == '0) begin
            num_reg <= numer;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= qbit ? 15'(trial - TURN_UNITS) : trial[14:0];
            num_reg <= {num_reg[NW-2:0], qbit};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = num_reg;

endmodule

FILE: sv/egdr_sine_rom.sv
module egdr_sine_rom import egdr_pkg::*; #(
    parameter int DEPTH = 1024
) (
    input  logic                         aclk,
    input  logic [$clog2(DEPTH+1)-1:0]   addr,
    output logic [MAG_W-1:0]             q
);
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic [MAG_W-1:0] tab_t [DEPTH+1];

    // quarter-wave sine in Q16 from a Taylor series in Q30
    function automatic tab_t build_table();
        tab_t        t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] prod;
        logic [63:0] rnd;
        longint      acc;
        for (int k = 0; k <= DEPTH; k++) begin
            x    = HALF_PI_Q30 * 64'(k) / 64'(DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n < 7; n++) begin
                prod = (term * x2) >> 30;
                case (n)
                    1: term = prod / 64'd6;
                    2: term = prod / 64'd20;
                    3: term = prod / 64'd42;
                    4: term = prod / 64'd72;
                    5: term = prod / 64'd110;
                    default: term = prod / 64'd156;
                endcase
                if (n % 2 == 1) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            rnd = (64'(acc) + 64'd8192) >> 14;
            if (rnd > 64'd65536) rnd = 64'd65536;
            t[k] = rnd[MAG_W-1:0];
        end
        t[DEPTH] = 17'd65536;
        return t;
    endfunction

    localparam tab_t SINE_TAB = build_table();

    // registered read
    always_ff @(posedge aclk) begin
        q <= SINE_TAB[addr];
    end

endmodule

FILE: sv/encoder_gyro_dead_reckoning_core.sv
// Dead-reckoning odometry core for a two-wheel drive.
// Input channel (s_valid/s_ready): one sample of both encoder counts, yaw and
// the start and re-zero flags. Result channel (m_valid/m_ready): X, Y, step
// distance and run distance after that sample, one result per sample.
// Configuration channel (cfg_valid/cfg_ready, always ready): writes
// mm_per_count; write it only while the core is idle.
// A sample passes through preparation, the step-distance product beside the
// angle division, the sine and cosine table reads, the X and Y products and
// the output load. The work is done by the bit-serial multiplier (three
// products in turn) and the bit-serial angle divider, NW = 15 + clog2(4 *
// depth) bits wide, which runs beside the first product.
// One sample is worked on at a time: a new sample is taken only once the
// previous result sits in the output register, even if the receiver has not
// yet taken it.
// A stalled receiver holds the result in the output register; the core then
// finishes at most one further sample and waits before loading it.
// Synchronous active-low reset clears position, distance and previous counts,
// sets mm_per_count to 0.5 mm and leaves no result pending.
`include "encoder_gyro_dead_reckoning_core_defines.svh"

module encoder_gyro_dead_reckoning_core import egdr_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [MM_W-1:0]            cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [15:0]         s_left_count,
    input  logic signed [15:0]         s_right_count,
    input  logic signed [15:0]         s_yaw_angle,
    input  logic                       s_start_run,
    input  logic                       s_rezero,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [POS_W-1:0]    m_x_position,
    output logic signed [POS_W-1:0]    m_y_position,
    output logic signed [STEP_W-1:0]   m_step_distance,
    output logic signed [POS_W-1:0]    m_run_distance
);
    localparam int D      = SINE_TABLE_DEPTH;
    localparam int FULL   = 4 * D;
    localparam int QW     = $clog2(FULL);
    localparam int NW     = 15 + QW;
    localparam int RAW    = $clog2(D + 1);
    localparam int MAW    = STEP_W;
    localparam int MBW    = MM_W;
    localparam int PW     = MAW + MBW;
    localparam int XPW    = STEP_W + MAG_W;

    state_t state_reg, state_next;

    logic [MM_W-1:0]          mm_reg;
    logic signed [15:0]       left_reg, right_reg, yaw_reg;
    logic                     start_reg, rezero_reg;
    logic signed [15:0]       prev_left_reg, prev_right_reg;
    logic signed [POS_W-1:0]  pos_x_reg, pos_y_reg, total_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic [QW-1:0]            idx_reg;
    logic [MAG_W-1:0]         sin_mag_reg, cos_mag_reg;
    logic                     sin_neg_reg, cos_neg_reg;
    logic                     m_valid_reg;

    logic signed [17:0]       sum;
    logic [14:0]              phase;
    logic [NW-1:0]            numer;
    logic [QW-1:0]            cos_idx;
    logic [RAW:0]             sin_sel, cos_sel;
    logic [RAW-1:0]           rom_addr;
    logic [MAG_W-1:0]         rom_q;
    logic                     mul_start, mul_busy;
    logic signed [MAW-1:0]    mul_a;
    logic [MBW-1:0]           mul_b;
    logic signed [PW-1:0]     mul_p;
    logic                     div_start, div_busy;
    logic [NW-1:0]            div_q;
    logic signed [XPW-1:0]    xp_raw, xp_adj;
    logic signed [INC_W-1:0]  inc;
    logic                     cur_neg;
    logic                     out_free;

    // map a full-wave index to {negate, quarter-table address}
    function automatic logic [RAW:0] wave_sel(input logic [QW-1:0] i);
        logic [QW-1:0] off;
        logic [1:0]    quad;
        if (i >= QW'(3 * D)) begin
            quad = 2'd3;
            off  = i - QW'(3 * D);
        end else if (i >= QW'(2 * D)) begin
            quad = 2'd2;
            off  = i - QW'(2 * D);
        end else if (i >= QW'(D)) begin
            quad = 2'd1;
            off  = i - QW'(D);
        end else begin
            quad = 2'd0;
            off  = i;
        end
        wave_sel = {quad[1], quad[0] ? RAW'(D) - RAW'(off) : RAW'(off)};
    endfunction

    egdr_serial_mul #(.AW(MAW), .BW(MBW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .busy    (mul_busy),
        .product (mul_p)
    );

    egdr_serial_div #(.NW(NW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (numer),
        .busy     (div_busy),
        .quotient (div_q)
    );

    egdr_sine_rom #(.DEPTH(D)) u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    // count changes, yaw reduced to one turn, angle numerator, sine and cosine selects
    always_comb begin
        sum = 18'(left_reg) - 18'(prev_left_reg) + 18'(right_reg) - 18'(prev_right_reg);
        if (yaw_reg < -16'sd23040) begin
            phase = 15'(17'(yaw_reg) + 17'sd46080);
        end else if (yaw_reg < 16'sd0) begin
            phase = 15'(17'(yaw_reg) + 17'sd23040);
        end else if (yaw_reg >= 16'sd23040) begin
            phase = 15'(yaw_reg - 16'sd23040);
        end else begin
            phase = yaw_reg[14:0];
        end
        numer   = NW'(phase) * NW'(FULL);
        cos_idx = (idx_reg >= QW'(3 * D)) ? idx_reg - QW'(3 * D) : idx_reg + QW'(D);
        sin_sel = wave_sel(idx_reg);
        cos_sel = wave_sel(cos_idx);
    end

    // signed increment from the last product
    always_comb begin
        cur_neg = (state_reg == ST_MUL_X) ? sin_neg_reg : cos_neg_reg;
        xp_raw  = mul_p[XPW-1:0];
        xp_adj  = cur_neg ? -xp_raw : xp_raw;
        inc     = xp_adj[XPW-1:16];
    end

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_PREP;
            ST_PREP:  state_next = ST_DIST;
            ST_DIST:  if (!mul_busy && !div_busy) state_next = ST_ROM_S;
            ST_ROM_S: state_next = ST_ROM_C;
            ST_ROM_C: state_next = ST_ROM_W;
            ST_ROM_W: state_next = ST_MUL_X;
            ST_MUL_X: if (!mul_busy) state_next = ST_MUL_Y;
            ST_MUL_Y: if (!mul_busy) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        div_start = (state_reg == ST_PREP);
        mul_start = 1'b0;
        mul_a     = step_reg;
        mul_b     = MBW'(sin_mag_reg);
        rom_addr  = sin_sel[RAW-1:0];
        case (state_reg)
            ST_PREP: begin
                mul_start = 1'b1;
                mul_a     = MAW'(sum);
                mul_b     = mm_reg;
            end
            ST_ROM_C: rom_addr = cos_sel[RAW-1:0];
            ST_ROM_W: mul_start = 1'b1;
            ST_MUL_X: begin
                mul_start = !mul_busy;
                mul_b     = MBW'(cos_mag_reg);
            end
            default: ;
        endcase
    end

    // control and accumulator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mm_reg         <= 24'd32768;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            total_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                mm_reg <= cfg_data;
            end
            if (state_reg == ST_PREP) begin
                prev_left_reg  <= rezero_reg ? 16'sd0 : left_reg;
                prev_right_reg <= rezero_reg ? 16'sd0 : right_reg;
            end
            if (state_reg == ST_DIST && state_next == ST_ROM_S) begin
                total_reg <= sat_add48(start_reg ? '0 : total_reg,
                                       INC_W'($signed(mul_p[STEP_W:1])));
            end
            if (state_reg == ST_MUL_X && !mul_busy) begin
                pos_x_reg <= sat_add48(pos_x_reg, inc);
            end
            if (state_reg == ST_MUL_Y && !mul_busy) begin
                pos_y_reg <= sat_add48(pos_y_reg, inc);
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            left_reg   <= s_left_count;
            right_reg  <= s_right_count;
            yaw_reg    <= s_yaw_angle;
            start_reg  <= s_start_run;
            rezero_reg <= s_rezero;
        end
        if (state_reg == ST_DIST && state_next == ST_ROM_S) begin
            step_reg <= mul_p[STEP_W:1];
            idx_reg  <= div_q[QW-1:0];
        end
        if (state_reg == ST_ROM_S) begin
            sin_neg_reg <= sin_sel[RAW];
            cos_neg_reg <= cos_sel[RAW];
        end
        if (state_reg == ST_ROM_C) begin
            sin_mag_reg <= rom_q;
        end
        if (state_reg == ST_ROM_W) begin
            cos_mag_reg <= rom_q;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_x_position    <= pos_x_reg;
            m_y_position    <= pos_y_reg;
            m_step_distance <= step_reg;
            m_run_distance  <= total_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;

    `EGDR_ASSERT_NXT(a_accept_prep, aclk, aresetn, s_valid && s_ready, state_reg == ST_PREP)
    `EGDR_ASSERT_IMP(a_mul_owner, aclk, aresetn, mul_busy, state_reg == ST_DIST || state_reg == ST_MUL_X || state_reg == ST_MUL_Y)
    `EGDR_ASSERT_IMP(a_div_owner, aclk, aresetn, div_busy, state_reg == ST_DIST)
    `EGDR_ASSERT_NXT(a_result_load, aclk, aresetn, state_reg == ST_DONE && out_free, m_valid_reg && state_reg == ST_IDLE)

endmodule

FILE: tb/tb_encoder_gyro_dead_reckoning_core.sv
`timescale 1ns / 100ps

module tb_encoder_gyro_dead_reckoning_core;
    import egdr_pkg::*;

    localparam int  DEPTH      = 1024;
    localparam int  TURN       = 23040;
    localparam int  WDOG_LIMIT = 6000;
    localparam int  HOLD_OFF   = 500;
    localparam int  TAIL_WAIT  = 200;
    localparam logic [MM_W-1:0] SCALE_RESET = 24'd32768;
    localparam logic [MM_W-1:0] SCALE_MAX   = 24'hFFFFFF;
    localparam longint POS_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint POS_MIN = -POS_MAX - 1;

    typedef struct {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [STEP_W-1:0] step;
        logic [POS_W-1:0]  run;
    } pose_t;

    // Scoreboard: tracks odometry state and holds the poses still owed
    class odometry_scoreboard;
        longint unsigned sine_q16[DEPTH+1];
        logic [MM_W-1:0] scale;
        int              prev_l, prev_r;
        longint          pos_x, pos_y, travel;
        pose_t           pending[$];
        int              errors;

        function new();
            longint unsigned x, x2, term, q;
            longint          acc;
            scale = SCALE_RESET;
            prev_l = 0; prev_r = 0;
            pos_x = 0; pos_y = 0; travel = 0;
            errors = 0;
            // quarter-wave table: Taylor series in Q30, rounded to Q16
            for (int k = 0; k <= DEPTH; k++) begin
                x = 64'd1686629713 * k / DEPTH;
                x2 = (x * x) >> 30;
                term = x;
                acc = x;
                for (int n = 1; n < 7; n++) begin
                    term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                    if (n % 2) acc -= term;
                    else acc += term;
                end
                if (acc < 0) acc = 0;
                q = (acc + 8192) >> 14;
                if (q > 65536) q = 65536;
                sine_q16[k] = q;
            end
            sine_q16[DEPTH] = 65536;
        endfunction

        function longint wave(int unsigned idx);
            int unsigned quad, off;
            longint      mag;
            quad = (idx / DEPTH) % 4;
            off = idx % DEPTH;
            mag = quad[0] ? sine_q16[DEPTH - off] : sine_q16[off];
            return quad[1] ? -mag : mag;
        endfunction

        function longint clamp48(longint v);
            if (v > POS_MAX) return POS_MAX;
            if (v < POS_MIN) return POS_MIN;
            return v;
        endfunction

        // Advance the pose for one accepted sample and queue the result
        function void note_sample(logic signed [15:0] l, logic signed [15:0] r,
                                  logic signed [15:0] yaw, logic st, logic rz);
            longint      sum, step;
            int          p;
            int unsigned idx;
            pose_t       e;
            if (st) travel = 0;
            sum = longint'(int'(l) - prev_l) + longint'(int'(r) - prev_r);
            step = (sum * longint'({40'd0, scale})) >>> 1;
            travel = clamp48(travel + step);
            p = int'(yaw) % TURN;
            if (p < 0) p += TURN;
            idx = 32'((longint'(p) * 4 * DEPTH) / TURN);
            pos_x = clamp48(pos_x + ((step * wave(idx)) >>> 16));
            pos_y = clamp48(pos_y + ((step * wave((idx + DEPTH) % (4 * DEPTH))) >>> 16));
            prev_l = rz ? 0 : int'(l);
            prev_r = rz ? 0 : int'(r);
            e.x = pos_x[POS_W-1:0];
            e.y = pos_y[POS_W-1:0];
            e.step = step[STEP_W-1:0];
            e.run = travel[POS_W-1:0];
            pending.push_back(e);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t: %s mismatch: got %h want %h", $time, what, got, want);
            errors++;
        endtask

        task check_result(pose_t got);
            pose_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", got.x, 0);
                return;
            end
            e = pending.pop_front();
            if (got.x !== e.x) report_mismatch("x_position", got.x, e.x);
            if (got.y !== e.y) report_mismatch("y_position", got.y, e.y);
            if (got.step !== e.step) report_mismatch("step_distance", got.step, e.step);
            if (got.run !== e.run) report_mismatch("run_distance", got.run, e.run);
        endtask
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [MM_W-1:0]          cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [15:0]       s_left_count = '0;
    logic signed [15:0]       s_right_count = '0;
    logic signed [15:0]       s_yaw_angle = '0;
    logic                     s_start_run = 1'b0;
    logic                     s_rezero = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [POS_W-1:0]  m_x_position;
    logic signed [POS_W-1:0]  m_y_position;
    logic signed [STEP_W-1:0] m_step_distance;
    logic signed [POS_W-1:0]  m_run_distance;

    odometry_scoreboard sb = new();
    int  samples_sent = 0;
    bit  calm = 1'b0;
    int  quiet_cycles = 0;
    logic signed [15:0] last_l = 0, last_r = 0;

    encoder_gyro_dead_reckoning_core #(.SINE_TABLE_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_left_count(s_left_count), .s_right_count(s_right_count),
        .s_yaw_angle(s_yaw_angle), .s_start_run(s_start_run), .s_rezero(s_rezero),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_x_position(m_x_position), .m_y_position(m_y_position),
        .m_step_distance(m_step_distance), .m_run_distance(m_run_distance)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Check each result transfer
    always @(posedge aclk) begin
        pose_t got;
        if (aresetn && m_valid && m_ready) begin
            got.x = m_x_position;
            got.y = m_y_position;
            got.step = m_step_distance;
            got.run = m_run_distance;
            sb.check_result(got);
        end
    end

    // Receiver: random stall bursts, one long hold-off so the core backs up
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (samples_sent == 150) begin
                m_ready <= 1'b0;
                n = 0;
                while (n < HOLD_OFF) begin
                    @(posedge aclk);
                    n++;
                end
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing transfers for too long
    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("tb_encoder_gyro_dead_reckoning_core NOT OK");
                $finish;
            end
        end
    end

    // Offer one sample, with an optional idle burst first; hold until transfer
    task send_sample(logic signed [15:0] l, logic signed [15:0] r,
                     logic signed [15:0] yaw, logic st, logic rz);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_left_count <= l;
        s_right_count <= r;
        s_yaw_angle <= yaw;
        s_start_run <= st;
        s_rezero <= rz;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(l, r, yaw, st, rz);
        last_l = rz ? 16'sd0 : l;
        last_r = rz ? 16'sd0 : r;
        samples_sent++;
    endtask

    // Drain every owed result, then write the scale register
    task set_scale(logic [MM_W-1:0] v);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.scale = v;
    endtask

    task random_samples(int n);
        logic signed [15:0] l, r, yaw;
        for (int i = 0; i < n; i++) begin
            // mostly plausible motion, the rest arbitrary counts
            if ($urandom_range(0, 9) < 6) begin
                l = last_l + $signed(16'($urandom_range(0, 400))) - 16'sd200;
                r = last_r + $signed(16'($urandom_range(0, 400))) - 16'sd200;
            end else begin
                l = 16'($urandom);
                r = 16'($urandom);
            end
            if ($urandom_range(0, 9) == 0) yaw = 16'($urandom);
            else yaw = $signed(16'($urandom_range(0, 2 * TURN))) - 16'sd23040;
            send_sample(l, r, yaw, $urandom_range(0, 19) == 0,
                        $urandom_range(0, 19) == 0);
        end
    endtask

    initial begin
        int guard;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: count and angle extremes, flags, out-of-turn yaw
        send_sample(16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0);
        send_sample(16'sd32767, 16'sd32767, 16'sd0, 1'b0, 1'b0);
        send_sample(-16'sd32768, -16'sd32768, 16'sd5760, 1'b0, 1'b0);
        send_sample(16'sd32767, -16'sd32768, 16'sd11520, 1'b0, 1'b0);
        send_sample(-16'sd32768, 16'sd32767, -16'sd5760, 1'b0, 1'b0);
        send_sample(16'sd100, 16'sd300, 16'sd23040, 1'b1, 1'b0);
        send_sample(16'sd500, 16'sd400, -16'sd23040, 1'b0, 1'b1);
        send_sample(16'sd20, 16'sd10, 16'sd32767, 1'b1, 1'b1);
        send_sample(-16'sd20, -16'sd10, -16'sd32768, 1'b0, 1'b0);
        send_sample(16'sd7, 16'sd9, 16'sd1, 1'b0, 1'b0);
        send_sample(16'sd8, 16'sd10, -16'sd1, 1'b0, 1'b0);
        send_sample(16'sd9, 16'sd11, 16'sd23039, 1'b0, 1'b0);
        send_sample(16'sd10, 16'sd12, 16'sd17280, 1'b0, 1'b0);
        send_sample(-16'sd1, -16'sd1, 16'sd2880, 1'b1, 1'b0);
        random_samples(200);

        // Zero scale: positions hold
        set_scale('0);
        random_samples(60);
        set_scale(24'd1);
        random_samples(150);

        // Full scale, driven far enough to saturate both ways
        set_scale(SCALE_MAX);
        for (int i = 0; i < 300; i++)
            send_sample(16'sd32767, 16'sd32767, $urandom_range(0, 1) ? 16'sd0 : 16'sd5760,
                        1'b0, 1'b1);
        for (int i = 0; i < 600; i++)
            send_sample(-16'sd32768, -16'sd32768,
                        $urandom_range(0, 1) ? 16'sd0 : 16'sd5760, 1'b0, 1'b1);
        random_samples(100);

        set_scale(24'($urandom));
        random_samples(300);

        // Final stretch with both sides always ready
        set_scale(24'($urandom_range(1, 1 << 20)));
        calm = 1'b1;
        random_samples(300);

        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        guard = 0;
        while (guard < TAIL_WAIT) begin
            @(posedge aclk);
            guard++;
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_encoder_gyro_dead_reckoning_core OK");
        else
            $display("tb_encoder_gyro_dead_reckoning_core NOT OK");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/egdr_pkg.sv
sv/egdr_serial_mul.sv
sv/egdr_serial_div.sv
sv/egdr_sine_rom.sv
sv/encoder_gyro_dead_reckoning_core.sv
tb/tb_encoder_gyro_dead_reckoning_core.sv
